// ===== design/fcull_pkg.sv =====
// Shared types and constants for the frustum box cull test.
package fcull_pkg;

	localparam int NUM_PLANES = 6;
	localparam int PLANE_W    = 64;
	localparam int IDX_W      = 3;
	localparam int COORD_W    = 24;
	localparam int COEF_W     = 12;
	localparam int D_W        = 28;
	localparam int FRAC_ALIGN = 10;
	localparam int PROD_W     = COEF_W + COORD_W;
	localparam int DSC_W      = D_W + FRAC_ALIGN;
	localparam int SUM_W      = DSC_W + 1;

	localparam int A_LSB = 0;
	localparam int B_LSB = 12;
	localparam int C_LSB = 24;
	localparam int D_LSB = 36;

	typedef enum logic [IDX_W-1:0] {
		PLANE_LEFT   = 3'd0,
		PLANE_RIGHT  = 3'd1,
		PLANE_BOTTOM = 3'd2,
		PLANE_TOP    = 3'd3,
		PLANE_NEAR   = 3'd4,
		PLANE_FAR    = 3'd5
	} plane_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	typedef struct packed {
		box_t box;
		logic pass;
		logic invalid;
	} token_t;

endpackage

// ===== design/frustum_box_cull_test_core.sv =====
// Top level of the frustum box cull test: input stage and a chain of six plane cells.
// A request passes one input stage, then a multiply stage and a sum stage in each plane cell.
// Throughput: one box per cycle while the output does not stall.
// A stalled output lets the chain fill its empty stages before the input stalls.
// Reset clears all valid flags and sets the six plane registers to zero.
// A zero plane passes every box.
module frustum_box_cull_test_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [fcull_pkg::IDX_W-1:0]         wr_index,
	input  logic [fcull_pkg::PLANE_W-1:0]       wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fcull_pkg::COORD_W-1:0] min_x,
	input  logic signed [fcull_pkg::COORD_W-1:0] min_y,
	input  logic signed [fcull_pkg::COORD_W-1:0] min_z,
	input  logic signed [fcull_pkg::COORD_W-1:0] max_x,
	input  logic signed [fcull_pkg::COORD_W-1:0] max_y,
	input  logic signed [fcull_pkg::COORD_W-1:0] max_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                visible,
	output logic                                box_invalid
);

	logic              valid_s0;
	fcull_pkg::token_t tok_s0;
	logic              ready_s0;
	logic              invalid;

	logic              vld [0:fcull_pkg::NUM_PLANES];
	logic              rdy [0:fcull_pkg::NUM_PLANES];
	fcull_pkg::token_t tok [0:fcull_pkg::NUM_PLANES];

	assign invalid = (min_x > max_x) || (min_y > max_y) || (min_z > max_z);

	assign ready_s0 = !valid_s0 || rdy[0];
	assign in_stall = !ready_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (ready_s0) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s0 && in_valid) begin
			tok_s0.box.min_x <= min_x;
			tok_s0.box.min_y <= min_y;
			tok_s0.box.min_z <= min_z;
			tok_s0.box.max_x <= max_x;
			tok_s0.box.max_y <= max_y;
			tok_s0.box.max_z <= max_z;
			tok_s0.pass      <= !invalid;
			tok_s0.invalid   <= invalid;
		end
	end

	assign vld[0] = valid_s0;
	assign tok[0] = tok_s0;

	for (genvar i = 0; i < fcull_pkg::NUM_PLANES; i++) begin : g_cell
		fcull_cell #(
			.PLANE(fcull_pkg::plane_idx_t'(i))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_index(wr_index),
			.wr_data (wr_data),
			.i_valid (vld[i]),
			.i_tok   (tok[i]),
			.i_ready (rdy[i]),
			.o_valid (vld[i+1]),
			.o_tok   (tok[i+1]),
			.o_ready (rdy[i+1])
		);
	end

	assign rdy[fcull_pkg::NUM_PLANES] = !out_stall;

	assign out_valid   = vld[fcull_pkg::NUM_PLANES];
	assign visible     = tok[fcull_pkg::NUM_PLANES].pass;
	assign box_invalid = tok[fcull_pkg::NUM_PLANES].invalid;

endmodule

// ===== design/fcull_cell.sv =====
// One plane cell: holds a plane register and tests the passing box against it in two stages.
module fcull_cell #(
	parameter fcull_pkg::plane_idx_t PLANE = fcull_pkg::PLANE_LEFT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fcull_pkg::IDX_W-1:0]      wr_index,
	input  logic [fcull_pkg::PLANE_W-1:0]    wr_data,
	input  logic                             i_valid,
	input  fcull_pkg::token_t                i_tok,
	output logic                             i_ready,
	output logic                             o_valid,
	output fcull_pkg::token_t                o_tok,
	input  logic                             o_ready
);

	logic [fcull_pkg::PLANE_W-1:0] plane_q;

	logic signed [fcull_pkg::COEF_W-1:0]  coef_a, coef_b, coef_c;
	logic signed [fcull_pkg::D_W-1:0]     coef_d;
	logic signed [fcull_pkg::COORD_W-1:0] px, py, pz;

	logic                                valid_s1, valid_s2;
	logic                                ready_s1, ready_s2;
	fcull_pkg::token_t                   tok_s1, tok_s2;
	fcull_pkg::token_t                   tok_nx;
	logic signed [fcull_pkg::PROD_W-1:0] pa_s1, pb_s1, pc_s1;
	logic signed [fcull_pkg::DSC_W-1:0]  dsc_s1;
	logic signed [fcull_pkg::SUM_W-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (wr_en && (wr_index == PLANE)) begin
			plane_q <= wr_data;
		end
	end

	assign coef_a = plane_q[fcull_pkg::A_LSB +: fcull_pkg::COEF_W];
	assign coef_b = plane_q[fcull_pkg::B_LSB +: fcull_pkg::COEF_W];
	assign coef_c = plane_q[fcull_pkg::C_LSB +: fcull_pkg::COEF_W];
	assign coef_d = plane_q[fcull_pkg::D_LSB +: fcull_pkg::D_W];

	// pick the corner furthest along the normal
	assign px = coef_a[fcull_pkg::COEF_W-1] ? i_tok.box.min_x : i_tok.box.max_x;
	assign py = coef_b[fcull_pkg::COEF_W-1] ? i_tok.box.min_y : i_tok.box.max_y;
	assign pz = coef_c[fcull_pkg::COEF_W-1] ? i_tok.box.min_z : i_tok.box.max_z;

	assign ready_s2 = !valid_s2 || o_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign i_ready  = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= i_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && i_valid) begin
			tok_s1 <= i_tok;
			pa_s1  <= coef_a * px;
			pb_s1  <= coef_b * py;
			pc_s1  <= coef_c * pz;
			dsc_s1 <= {coef_d, {fcull_pkg::FRAC_ALIGN{1'b0}}};
		end
	end

	assign sum = fcull_pkg::SUM_W'(pa_s1) + fcull_pkg::SUM_W'(pb_s1)
		+ fcull_pkg::SUM_W'(pc_s1) + fcull_pkg::SUM_W'(dsc_s1);

	always_comb begin
		tok_nx      = tok_s1;
		tok_nx.pass = tok_s1.pass && !sum[fcull_pkg::SUM_W-1];
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			tok_s2 <= tok_nx;
		end
	end

	assign o_valid = valid_s2;
	assign o_tok   = tok_s2;

endmodule

// ===== design/fcull_checker.sv =====
// Port-level checks for the frustum box cull test, bound to the top level.
module fcull_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                visible,
	input logic                                box_invalid
);

	a_invalid_not_visible: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && box_invalid |-> !visible)
		else $error("invalid box reported visible");

	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visible) && $stable(box_invalid))
		else $error("stalled result changed");

endmodule

bind frustum_box_cull_test_core fcull_checker u_fcull_checker (.*);

// ===== verif/frustum_box_cull_test_checker.sv =====
// Checker for the frustum box cull test core: predicts each box verdict and compares results.
`timescale 1ns / 100ps

module frustum_box_cull_test_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fcull_pkg::IDX_W-1:0]   wr_index,
	input  logic [fcull_pkg::PLANE_W-1:0] wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  fcull_pkg::box_t               req_box,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          visible,
	input  logic                          box_invalid,
	output int                            mismatches,
	output int                            outstanding
);

	typedef struct packed {
		logic visible;
		logic box_invalid;
	} verdict_t;

	logic [fcull_pkg::PLANE_W-1:0] plane_regs [fcull_pkg::NUM_PLANES];
	verdict_t                      pending_verdicts [$];
	verdict_t                      want;

	function automatic longint axis_term(logic signed [fcull_pkg::COEF_W-1:0] k,
		logic signed [fcull_pkg::COORD_W-1:0] lo, logic signed [fcull_pkg::COORD_W-1:0] hi);
		return longint'(k) * longint'((k < 0) ? lo : hi);
	endfunction

	function automatic logic axis_inverted(logic signed [fcull_pkg::COORD_W-1:0] lo,
		logic signed [fcull_pkg::COORD_W-1:0] hi);
		return lo > hi;
	endfunction

	function automatic logic plane_holds(logic [fcull_pkg::PLANE_W-1:0] p, fcull_pkg::box_t b);
		logic signed [fcull_pkg::D_W-1:0] ofs;
		longint acc;
		ofs = p[fcull_pkg::D_LSB +: fcull_pkg::D_W];
		acc = longint'(ofs) <<< fcull_pkg::FRAC_ALIGN;
		acc = acc + axis_term(p[fcull_pkg::A_LSB +: fcull_pkg::COEF_W], b.min_x, b.max_x)
			+ axis_term(p[fcull_pkg::B_LSB +: fcull_pkg::COEF_W], b.min_y, b.max_y)
			+ axis_term(p[fcull_pkg::C_LSB +: fcull_pkg::COEF_W], b.min_z, b.max_z);
		return acc >= 0;
	endfunction

	function automatic verdict_t cull_verdict(fcull_pkg::box_t b);
		verdict_t v;
		v.box_invalid = axis_inverted(b.min_x, b.max_x) || axis_inverted(b.min_y, b.max_y)
			|| axis_inverted(b.min_z, b.max_z);
		v.visible = !v.box_invalid;
		for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) begin
			if (!plane_holds(plane_regs[i], b))
				v.visible = 1'b0;
		end
		return v;
	endfunction

	task automatic flag_field(string field, logic expected, logic actual);
		if (expected !== actual) begin
			$display("%0t: %s expected %0b got %0b", $time, field, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcull_pkg::NUM_PLANES; i++)
				plane_regs[i] = '0;
			pending_verdicts.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (wr_en && wr_index < fcull_pkg::NUM_PLANES)
				plane_regs[wr_index] = wr_data;
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: result expected none got visible %0b box_invalid %0b",
						$time, visible, box_invalid);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					flag_field("visible", want.visible, visible);
					flag_field("box_invalid", want.box_invalid, box_invalid);
				end
			end
			if (in_valid && !in_stall)
				pending_verdicts.push_back(cull_verdict(req_box));
			outstanding = pending_verdicts.size();
		end
	end

endmodule

// ===== verif/frustum_box_cull_test_core_tb.sv =====
// Testbench top for the frustum box cull test core: box and plane stimulus, handshakes, verdict.
`timescale 1ns / 100ps

module frustum_box_cull_test_core_tb;

	typedef enum int {
		SCHEME_MIXED,
		SCHEME_RAW,
		SCHEME_OPEN
	} plane_scheme_t;

	localparam int PIPE_LATENCY      = 13;
	localparam int BOXES_PER_SETTING = 210;
	localparam logic signed [fcull_pkg::COORD_W-1:0] COORD_LO =
		{1'b1, {(fcull_pkg::COORD_W-1){1'b0}}};
	localparam logic signed [fcull_pkg::COORD_W-1:0] COORD_HI =
		{1'b0, {(fcull_pkg::COORD_W-1){1'b1}}};
	localparam logic signed [fcull_pkg::COORD_W-1:0] COORD_UNIT  = fcull_pkg::COORD_W'(256);
	localparam logic signed [fcull_pkg::COORD_W-1:0] COORD_NUNIT = fcull_pkg::COORD_W'(-256);
	localparam logic signed [fcull_pkg::COORD_W-1:0] COORD_EPS   = fcull_pkg::COORD_W'(1);
	localparam logic signed [fcull_pkg::COORD_W-1:0] COORD_ZERO  = '0;
	localparam logic [fcull_pkg::COEF_W-1:0] COEF_MAX = {1'b0, {(fcull_pkg::COEF_W-1){1'b1}}};
	localparam logic [fcull_pkg::COEF_W-1:0] COEF_MIN = {1'b1, {(fcull_pkg::COEF_W-1){1'b0}}};
	localparam logic [fcull_pkg::D_W-1:0]    DIST_MAX = {1'b0, {(fcull_pkg::D_W-1){1'b1}}};
	localparam logic [fcull_pkg::D_W-1:0]    DIST_MIN = {1'b1, {(fcull_pkg::D_W-1){1'b0}}};

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          wr_en     = 1'b0;
	logic [fcull_pkg::IDX_W-1:0]   wr_index  = '0;
	logic [fcull_pkg::PLANE_W-1:0] wr_data   = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	fcull_pkg::box_t               req       = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          visible;
	logic                          box_invalid;
	int                            mismatches;
	int                            outstanding;
	int                            send_idle_pct = 0;
	int                            recv_idle_pct = 0;
	logic [fcull_pkg::PLANE_W-1:0] plane_set [fcull_pkg::NUM_PLANES];

	frustum_box_cull_test_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.min_x      (req.min_x),
		.min_y      (req.min_y),
		.min_z      (req.min_z),
		.max_x      (req.max_x),
		.max_y      (req.max_y),
		.max_z      (req.max_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.visible    (visible),
		.box_invalid(box_invalid)
	);

	frustum_box_cull_test_checker verdict_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_box    (req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.visible    (visible),
		.box_invalid(box_invalid),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [fcull_pkg::PLANE_W-1:0] pack_plane(
		logic [fcull_pkg::COEF_W-1:0] ka, logic [fcull_pkg::COEF_W-1:0] kb,
		logic [fcull_pkg::COEF_W-1:0] kc, logic [fcull_pkg::D_W-1:0] ofs);
		return {ofs, kc, kb, ka};
	endfunction

	function automatic fcull_pkg::box_t mk_box(logic signed [fcull_pkg::COORD_W-1:0] lx,
		logic signed [fcull_pkg::COORD_W-1:0] ly, logic signed [fcull_pkg::COORD_W-1:0] lz,
		logic signed [fcull_pkg::COORD_W-1:0] hx, logic signed [fcull_pkg::COORD_W-1:0] hy,
		logic signed [fcull_pkg::COORD_W-1:0] hz);
		fcull_pkg::box_t b;
		b.min_x = lx;
		b.min_y = ly;
		b.min_z = lz;
		b.max_x = hx;
		b.max_y = hy;
		b.max_z = hz;
		return b;
	endfunction

	function automatic fcull_pkg::box_t random_box();
		logic signed [fcull_pkg::COORD_W-1:0] lo [3];
		logic signed [fcull_pkg::COORD_W-1:0] hi [3];
		logic signed [fcull_pkg::COORD_W-1:0] tmp;
		logic [fcull_pkg::COORD_W-1:0]        span;
		int                                   k;
		for (int i = 0; i < 3; i++) begin
			lo[i] = fcull_pkg::COORD_W'($urandom);
			case ($urandom_range(9))
				0: hi[i] = fcull_pkg::COORD_W'($urandom);
				1: hi[i] = lo[i];
				default: begin
					lo[i] = lo[i] >>> $urandom_range(fcull_pkg::COORD_W-1);
					span = fcull_pkg::COORD_W'($urandom);
					span = span >> $urandom_range(fcull_pkg::COORD_W-1);
					hi[i] = lo[i] + span;
				end
			endcase
		end
		if ($urandom_range(11) == 0) begin
			k = $urandom_range(2);
			tmp = lo[k];
			lo[k] = hi[k];
			hi[k] = tmp;
		end
		return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endfunction

	function automatic logic [fcull_pkg::PLANE_W-1:0] random_plane(plane_scheme_t scheme);
		logic [fcull_pkg::COEF_W-1:0]     ka;
		logic [fcull_pkg::COEF_W-1:0]     kb;
		logic [fcull_pkg::COEF_W-1:0]     kc;
		logic signed [fcull_pkg::D_W-1:0] ofs;
		ka = fcull_pkg::COEF_W'($urandom);
		kb = fcull_pkg::COEF_W'($urandom);
		kc = fcull_pkg::COEF_W'($urandom);
		ofs = fcull_pkg::D_W'($urandom);
		if (scheme == SCHEME_RAW)
			return {$urandom, $urandom};
		if ($urandom_range(3) == 0)
			return '0;
		case ($urandom_range(7))
			0: ka = '0;
			1: kb = '0;
			2: kc = '0;
			default: ;
		endcase
		if (scheme == SCHEME_OPEN)
			ofs[fcull_pkg::D_W-1] = 1'b0;
		ofs = ofs >>> $urandom_range(fcull_pkg::D_W-1);
		return pack_plane(ka, kb, kc, ofs);
	endfunction

	task automatic push_box(fcull_pkg::box_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	// write every plane, then the unused indexes, which the block must drop
	task automatic load_planes();
		for (int i = 0; i < (1 << fcull_pkg::IDX_W); i++) begin
			wr_en <= 1'b1;
			wr_index <= fcull_pkg::IDX_W'(i);
			wr_data <= (i < fcull_pkg::NUM_PLANES) ? plane_set[i] : {$urandom, $urandom};
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic run_corner_boxes();
		push_box(mk_box(COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO));
		push_box(mk_box(COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI));
		push_box(mk_box(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
		push_box(mk_box(COORD_NUNIT, COORD_NUNIT, COORD_NUNIT,
			COORD_UNIT, COORD_UNIT, COORD_UNIT));
		push_box(mk_box(COORD_EPS, COORD_LO, COORD_LO, COORD_ZERO, COORD_HI, COORD_HI));
		push_box(mk_box(COORD_LO, COORD_EPS, COORD_LO, COORD_HI, COORD_ZERO, COORD_HI));
		push_box(mk_box(COORD_LO, COORD_LO, COORD_EPS, COORD_HI, COORD_HI, COORD_ZERO));
		push_box(mk_box(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct <= 20;
		recv_idle_pct <= 88;

		// planes still at their reset value
		run_corner_boxes();

		settle();
		plane_set[fcull_pkg::PLANE_LEFT]   = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, DIST_MAX);
		plane_set[fcull_pkg::PLANE_RIGHT]  = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, '0);
		plane_set[fcull_pkg::PLANE_BOTTOM] = '0;
		plane_set[fcull_pkg::PLANE_TOP]    =
			pack_plane('0, COEF_MIN, COEF_MAX, fcull_pkg::D_W'(1));
		plane_set[fcull_pkg::PLANE_NEAR]   = '1;
		plane_set[fcull_pkg::PLANE_FAR]    = pack_plane(COEF_MIN, '0, COEF_MAX, DIST_MAX);
		load_planes();
		run_corner_boxes();

		settle();
		plane_set[fcull_pkg::PLANE_LEFT]   = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, DIST_MAX);
		plane_set[fcull_pkg::PLANE_RIGHT]  = pack_plane(COEF_MAX, COEF_MIN, '0, DIST_MAX);
		plane_set[fcull_pkg::PLANE_BOTTOM] = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, DIST_MIN);
		plane_set[fcull_pkg::PLANE_TOP]    = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, DIST_MIN);
		plane_set[fcull_pkg::PLANE_NEAR]   = '0;
		plane_set[fcull_pkg::PLANE_FAR]    = '1;
		load_planes();
		run_corner_boxes();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct <= (mode == 0) ? 20 : (mode == 1) ? 88 : 0;
			recv_idle_pct <= (mode == 0) ? 88 : (mode == 1) ? 20 : 0;
			for (int s = SCHEME_MIXED; s <= SCHEME_OPEN; s++) begin
				settle();
				for (int i = 0; i < fcull_pkg::NUM_PLANES; i++)
					plane_set[i] = random_plane(plane_scheme_t'(s));
				load_planes();
				repeat (BOXES_PER_SETTING) push_box(random_box());
			end
		end

		settle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
